// File: design/brp_pkg.sv
// Shared constants, types and helper functions of the basis regression predictor.
// No dependencies; every module of the block imports this package.
`default_nettype none

package brp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int X_W       = 24;
  localparam int W_W       = 24;
  localparam int Y_W       = 32;
  localparam int IDX_W     = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_BIAS   = 2'd0,
    REG_LINEAR = 2'd1,
    REG_SINE   = 2'd2,
    REG_GAUSS  = 2'd3
  } reg_idx_t;

  localparam logic signed [W_W-1:0] BIAS_RST   = -24'sd36304;
  localparam logic signed [W_W-1:0] LINEAR_RST = 24'sd65536;
  localparam logic signed [W_W-1:0] SINE_RST   = 24'sd655360;
  localparam logic signed [W_W-1:0] GAUSS_RST  = 24'sd586440;

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [29:0] Q30_HALF = 30'h2000_0000;

  // 1/(2*pi) in Q40, split into two 19-bit halves for the phase multiply.
  localparam logic [37:0] INV_TWO_PI_Q40 = 38'd174992710548;
  localparam int          PHASE_SPLIT    = 19;
  localparam logic [18:0] INV_2PI_LO     = INV_TWO_PI_Q40[18:0];
  localparam logic [18:0] INV_2PI_HI     = INV_TWO_PI_Q40[37:19];

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;

  // Reciprocal of ln2 used to estimate the power-of-two count of x*x.
  localparam int          K_SHIFT = 40;
  localparam logic [10:0] K_RECIP = 11'((64'd1 << K_SHIFT) / 64'(LN2_Q30));

  localparam int SINE_STEPS  = 6;
  localparam int GAUSS_STEPS = 11;
  localparam int STEP_LAT    = 3;

  typedef struct packed {
    logic [1:0]  quad;
    logic [30:0] ang;
  } sine_side_t;

  typedef struct packed {
    logic       zero;
    logic [5:0] k;
  } gauss_side_t;

  // Divisor of each Horner step: the sine series runs over 156 down to 6,
  // the exponential series over 11 down to 1.
  function automatic logic [7:0] brp_div(input logic is_sine, input int step);
    logic [7:0] d;
    if (is_sine) begin
      case (step)
        0:       d = 8'd156;
        1:       d = 8'd110;
        2:       d = 8'd72;
        3:       d = 8'd42;
        4:       d = 8'd20;
        default: d = 8'd6;
      endcase
    end else begin
      d = 8'(GAUSS_STEPS - step);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: design/brp_sine_front.sv
// Front end of the sin(3x) feature: phase in turns, quadrant fold and squared angle.
// Depends on brp_pkg. Four register stages.
`default_nettype none

module brp_sine_front (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [brp_pkg::X_W-1:0]   x_i,
  output logic         [31:0]                   ang2_o,
  output brp_pkg::sine_side_t                   side_o
);
  import brp_pkg::*;

  logic signed [25:0] t;
  logic signed [45:0] plo_r;
  logic signed [45:0] phi_r;
  logic signed [63:0] prod;
  logic        [31:0] phase;
  logic        [30:0] r_fold;
  logic        [61:0] angp_r;
  logic        [1:0]  quad2_r;
  logic        [30:0] ang_r;
  logic        [1:0]  quad3_r;
  logic        [61:0] ang2p;
  logic        [31:0] ang2_r;
  logic        [30:0] ang4_r;
  logic        [1:0]  quad4_r;

  assign t = 26'(x_i) + (26'(x_i) <<< 1);

  // Only the low 56 bits of 3x/(2pi) matter: the phase wraps every turn.
  assign prod   = (64'(phi_r) <<< PHASE_SPLIT) + 64'(plo_r);
  assign phase  = prod[55:24];
  assign r_fold = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  assign ang2p  = 62'(ang_r) * 62'(ang_r);

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r   <= t * $signed({1'b0, INV_2PI_LO});
      phi_r   <= t * $signed({1'b0, INV_2PI_HI});
      angp_r  <= 62'(r_fold) * 62'(HALF_PI_Q30);
      quad2_r <= phase[31:30];
      ang_r   <= 31'((angp_r + 62'(Q30_HALF)) >> 30);
      quad3_r <= quad2_r;
      ang2_r  <= 32'((ang2p + 62'(Q30_HALF)) >> 30);
      ang4_r  <= ang_r;
      quad4_r <= quad3_r;
    end
  end

  assign ang2_o      = ang2_r;
  assign side_o.quad = quad4_r;
  assign side_o.ang  = ang4_r;

endmodule

`default_nettype wire

// File: design/brp_gauss_front.sv
// Front end of the exp(-x*x) feature: x*x and its split into k*ln2 + r.
// Depends on brp_pkg. Three register stages.
`default_nettype none

module brp_gauss_front (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [brp_pkg::X_W-1:0]   x_i,
  output logic         [29:0]                   r_o,
  output brp_pkg::gauss_side_t                  side_o
);
  import brp_pkg::*;

  logic [23:0] a;
  logic [47:0] a2_r;
  logic [47:0] z_full;
  logic [34:0] z2_r;
  logic [45:0] kp2_r;
  logic        zero2_r;
  logic [5:0]  k0;
  logic [35:0] kl;
  logic [35:0] rem;
  logic        fix;
  logic [29:0] r3_r;
  logic [5:0]  k3_r;
  logic        zero3_r;

  assign a      = x_i[23] ? (24'd0 - 24'(x_i)) : 24'(x_i);
  assign z_full = (a2_r + 48'd2) >> 2;
  assign k0     = kp2_r[45:40];
  assign kl     = 36'(k0) * 36'(LN2_Q30);
  assign rem    = {1'b0, z2_r} - kl;
  assign fix    = (rem >= 36'(LN2_Q30));

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r    <= 48'(a) * 48'(a);
      // At x*x of 32 or more the feature is below one LSB.
      zero2_r <= (a2_r >= (48'd32 << (2 * FRAC_BITS)));
      z2_r    <= z_full[34:0];
      kp2_r   <= 46'(z_full[34:0]) * 46'(K_RECIP);
      zero3_r <= zero2_r;
      k3_r    <= fix ? (k0 + 6'd1) : k0;
      r3_r    <= fix ? 30'(rem - 36'(LN2_Q30)) : 30'(rem);
    end
  end

  assign r_o         = r3_r;
  assign side_o.zero = zero3_r;
  assign side_o.k    = k3_r;

endmodule

`default_nettype wire

// File: design/brp_horner.sv
// Pipelined Horner chain acc = 1 - c*acc/d, three register stages per step.
// Depends on brp_pkg for the step divisors and Q30 constants.
`default_nettype none

module brp_horner #(
  parameter int   NSTEP   = 6,
  parameter logic IS_SINE = 1'b1,
  parameter int   C_W     = 32,
  parameter int   SIDE_W  = 33
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [C_W-1:0]    c_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic      [30:0]       acc_o,
  output logic      [SIDE_W-1:0] side_o
);
  import brp_pkg::*;

  localparam int PW = C_W + 31;

  logic [30:0]       acc_s  [0:NSTEP];
  logic [C_W-1:0]    c_s    [0:NSTEP];
  logic [SIDE_W-1:0] side_s [0:NSTEP];

  assign acc_s[0]  = Q30_ONE;
  assign c_s[0]    = c_i;
  assign side_s[0] = side_i;

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam logic [7:0]  D = brp_div(IS_SINE, j);
    localparam logic [32:0] R = 33'((64'd1 << 32) / 64'(D));

    logic [PW-1:0]     prod;
    logic [31:0]       m1_r;
    logic [31:0]       m2_r;
    logic [64:0]       q2_r;
    logic [31:0]       q0;
    logic [39:0]       rem;
    logic [31:0]       q;
    logic [30:0]       acc3_r;
    logic [C_W-1:0]    c1_r, c2_r, c3_r;
    logic [SIDE_W-1:0] s1_r, s2_r, s3_r;

    assign prod = PW'(c_s[j]) * PW'(acc_s[j]);
    // The reciprocal estimate is at most one short; one compare corrects it.
    assign q0   = q2_r[63:32];
    assign rem  = 40'(m2_r) - 40'(q0) * 40'(D);
    assign q    = (rem >= 40'(D)) ? (q0 + 32'd1) : q0;

    always_ff @(posedge clk) begin
      if (en) begin
        m1_r   <= 32'((prod + PW'(Q30_HALF)) >> 30);
        c1_r   <= c_s[j];
        s1_r   <= side_s[j];
        q2_r   <= 65'(m1_r) * 65'(R);
        m2_r   <= m1_r;
        c2_r   <= c1_r;
        s2_r   <= s1_r;
        acc3_r <= Q30_ONE - q[30:0];
        c3_r   <= c2_r;
        s3_r   <= s2_r;
      end
    end

    assign acc_s[j+1]  = acc3_r;
    assign c_s[j+1]    = c3_r;
    assign side_s[j+1] = s3_r;
  end

  assign acc_o  = acc_s[NSTEP];
  assign side_o = side_s[NSTEP];

endmodule

`default_nettype wire

// File: design/basis_regression_predict_core.sv
// Top level of the basis regression predictor: y = w0 + w1*x + w2*sin(3x) + w3*exp(-x*x).
// Depends on brp_pkg, brp_sine_front, brp_gauss_front and brp_horner.
`default_nettype none

// One sample enters per clock while the output is not stalled; results are signed
// Q16.16. The depth of the pipeline is set by the exp(-x*x) path (three front
// stages, eleven Horner steps of three stages each, one scaling stage) followed by
// a product stage and a rounding stage. The whole pipeline advances together, so a
// stalled output holds every stage and nothing is lost. The user must write weights
// through the cfg_ port only while the pipeline is empty; the block does not enforce it.
module basis_regression_predict_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [brp_pkg::X_W-1:0]       in_sample_x,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [brp_pkg::Y_W-1:0]            out_prediction,
  input  wire logic                                 cfg_we,
  input  wire logic        [brp_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic        [brp_pkg::W_W-1:0]       cfg_wdata
);
  import brp_pkg::*;

  localparam int SINE_FRONT  = 4;
  localparam int GAUSS_FRONT = 3;
  localparam int SINE_LAT    = SINE_FRONT + SINE_STEPS * STEP_LAT + 2;
  localparam int GAUSS_LAT   = GAUSS_FRONT + GAUSS_STEPS * STEP_LAT + 1;
  localparam int SDLY        = GAUSS_LAT - SINE_LAT;
  localparam int XDLY        = GAUSS_LAT;
  localparam int LAT         = GAUSS_LAT + 2;

  logic                    pipe_en;
  logic [LAT:1]            vld_r;
  logic signed [W_W-1:0]   bias_w_r, lin_w_r, sine_w_r, gauss_w_r;

  logic [31:0]             ang2;
  sine_side_t              sside_f, sside_h;
  logic [30:0]             sacc;
  logic [29:0]             gr;
  gauss_side_t             gside_f, gside_h;
  logic [30:0]             gacc;

  logic [61:0]             sp_r;
  logic [1:0]              sq_r;
  logic [32:0]             s_full;
  logic [30:0]             s_clamp;
  logic [16:0]             s_round;
  logic signed [17:0]      sfeat_r;
  logic signed [17:0]      sd_r [1:SDLY];

  logic [6:0]              gsh;
  logic [63:0]             g_full;
  logic [16:0]             gfeat_r;

  logic signed [X_W-1:0]   xd_r [1:XDLY];

  logic signed [39:0]      p_bias_r;
  logic signed [47:0]      p_lin_r;
  logic signed [41:0]      p_sin_r;
  logic signed [41:0]      p_gau_r;
  logic signed [49:0]      sum;
  logic signed [Y_W-1:0]   out_prediction_r;

  assign pipe_en  = out_ready | ~vld_r[LAT];
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_w_r  <= BIAS_RST;
      lin_w_r   <= LINEAR_RST;
      sine_w_r  <= SINE_RST;
      gauss_w_r <= GAUSS_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BIAS:   bias_w_r  <= cfg_wdata;
        REG_LINEAR: lin_w_r   <= cfg_wdata;
        REG_SINE:   sine_w_r  <= cfg_wdata;
        REG_GAUSS:  gauss_w_r <= cfg_wdata;
      endcase
    end
  end

  brp_sine_front u_sine_front (
    .clk    (clk),
    .en     (pipe_en),
    .x_i    (in_sample_x),
    .ang2_o (ang2),
    .side_o (sside_f)
  );

  brp_horner #(
    .NSTEP   (SINE_STEPS),
    .IS_SINE (1'b1),
    .C_W     (32),
    .SIDE_W  ($bits(sine_side_t))
  ) u_sine_horner (
    .clk    (clk),
    .en     (pipe_en),
    .c_i    (ang2),
    .side_i (sside_f),
    .acc_o  (sacc),
    .side_o (sside_h)
  );

  brp_gauss_front u_gauss_front (
    .clk    (clk),
    .en     (pipe_en),
    .x_i    (in_sample_x),
    .r_o    (gr),
    .side_o (gside_f)
  );

  brp_horner #(
    .NSTEP   (GAUSS_STEPS),
    .IS_SINE (1'b0),
    .C_W     (30),
    .SIDE_W  ($bits(gauss_side_t))
  ) u_gauss_horner (
    .clk    (clk),
    .en     (pipe_en),
    .c_i    (gr),
    .side_i (gside_f),
    .acc_o  (gacc),
    .side_o (gside_h)
  );

  // sin = ang * series, clamped to one and rounded to the output fraction.
  assign s_full  = 33'((sp_r + 62'(Q30_HALF)) >> 30);
  assign s_clamp = (s_full > 33'(Q30_ONE)) ? Q30_ONE : s_full[30:0];
  assign s_round = 17'((32'(s_clamp) + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));

  // exp(-x*x) = series * 2^-k, scaled to the output fraction with rounding.
  assign gsh    = 7'(gside_h.k) + 7'(30 - FRAC_BITS);
  assign g_full = (64'(gacc) + (64'd1 << (gsh - 7'd1))) >> gsh;

  assign sum = 50'(p_bias_r) + 50'(p_lin_r) + 50'(p_sin_r) + 50'(p_gau_r)
             + (50'sd1 <<< (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sp_r    <= 62'(sside_h.ang) * 62'(sacc);
      sq_r    <= sside_h.quad;
      sfeat_r <= sq_r[1] ? -$signed({1'b0, s_round}) : $signed({1'b0, s_round});
      sd_r[1] <= sfeat_r;
      for (int i = 2; i <= SDLY; i++) begin
        sd_r[i] <= sd_r[i-1];
      end

      gfeat_r <= (gside_h.zero || (gsh > 7'd62)) ? 17'd0 : g_full[16:0];

      xd_r[1] <= in_sample_x;
      for (int i = 2; i <= XDLY; i++) begin
        xd_r[i] <= xd_r[i-1];
      end

      p_bias_r <= 40'(bias_w_r) <<< FRAC_BITS;
      p_lin_r  <= 48'(lin_w_r) * 48'(xd_r[XDLY]);
      p_sin_r  <= 42'(sine_w_r) * 42'(sd_r[SDLY]);
      p_gau_r  <= 42'(gauss_w_r) * $signed(42'({1'b0, gfeat_r}));

      out_prediction_r <= 32'(sum >>> FRAC_BITS);
    end
  end

  assign out_valid      = vld_r[LAT];
  assign out_prediction = out_prediction_r;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("valid bits moved while the pipeline was stalled");

  a_gauss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && vld_r[GAUSS_LAT-1] && gside_h.zero |=> gfeat_r == 17'd0)
    else $error("gaussian feature not zero for a large sample");

  a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SINE_LAT] |-> (sfeat_r <= 18'sd65536) && (sfeat_r >= -18'sd65536))
    else $error("sine feature outside one");

endmodule

`default_nettype wire

// File: tb/tb_basis_regression_predict_core.sv
// Self-checking testbench for basis_regression_predict_core: a bit-exact predictor of
// the weighted basis sum, a queue-fed driver and a monitor. Depends on brp_pkg.
`timescale 1ns / 1ps

module tb_basis_regression_predict_core;
  import brp_pkg::*;

  localparam int  PIPE_LAT  = 39;
  localparam int  LIMIT     = 400000;
  localparam int  N_PHASES  = 8;
  localparam int  PER_PHASE = 235;
  localparam logic [63:0] INV_2PI = 64'd174992710548;
  localparam logic [63:0] HALF_PI = 64'd1686629713;
  localparam logic [63:0] LN2     = 64'd744261118;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam int SINE_DIV [6] = '{156, 110, 72, 42, 20, 6};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [X_W-1:0]   in_sample_x = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [Y_W-1:0]   out_prediction;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [W_W-1:0]          cfg_wdata = '0;

  basis_regression_predict_core dut (.*);

  logic [X_W-1:0]   pending_x [$];
  logic [Y_W-1:0]   expected_y [$];
  longint           weight [4];
  int               errors = 0;
  int               n_taken = 0;
  int               n_checked = 0;
  longint unsigned  cycles = 0;
  logic             taken_q = 1'b0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               hold_left = 0;
  int               stall_mode = 0;
  int               mode_left = 0;
  bit               long_hold_done = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
    return (a * b + (ONE_Q30 >> 1)) >> 30;
  endfunction

  function automatic longint sine_of_3x(longint x);
    logic [63:0] t, prod, r, ang, ang2, acc, s;
    logic [31:0] phase;
    logic [1:0]  quad;
    t = 64'(3 * x);
    prod = t * INV_2PI;
    phase = prod[55:24];
    quad = phase[31:30];
    r = quad[0] ? ONE_Q30 - 64'(phase[29:0]) : 64'(phase[29:0]);
    ang = (r * HALF_PI + (ONE_Q30 >> 1)) >> 30;
    ang2 = mulq(ang, ang);
    acc = ONE_Q30;
    for (int i = 0; i < 6; i++) acc = ONE_Q30 - mulq(ang2, acc) / 64'(SINE_DIV[i]);
    s = mulq(ang, acc);
    if (s > ONE_Q30) s = ONE_Q30;
    s = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint gauss_of_x(longint x);
    logic [63:0] a, a2, z, k, r, acc, sh;
    a = 64'(x < 0 ? -x : x);
    a2 = a * a;
    if (a2 >= (64'd32 << (2 * FRAC_BITS))) return 0;
    z = (a2 + 64'd2) >> 2;
    k = z / LN2;
    r = z - k * LN2;
    acc = ONE_Q30;
    for (int n = 11; n >= 1; n--) acc = ONE_Q30 - mulq(r, acc) / 64'(n);
    sh = k + 64'(30 - FRAC_BITS);
    if (sh > 62) return 0;
    return longint'((acc + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic logic [Y_W-1:0] predict_y(logic signed [X_W-1:0] xs);
    longint x, acc;
    x = longint'(xs);
    acc = (weight[REG_BIAS] <<< FRAC_BITS) + weight[REG_LINEAR] * x
        + weight[REG_SINE] * sine_of_3x(x) + weight[REG_GAUSS] * gauss_of_x(x);
    acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return acc[Y_W-1:0];
  endfunction

  // Mostly samples where the features are lively, the rest anywhere in range.
  function automatic logic [X_W-1:0] random_x();
    case ($urandom_range(0, 3))
      0:       return X_W'($urandom);
      1:       return X_W'($signed($urandom_range(0, 786432)) - 393216);
      2:       return X_W'($signed($urandom_range(0, 8192)) + 366631) ^
                      ($urandom_range(0, 1) ? {X_W{1'b1}} : '0);
      default: return X_W'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Input side: record accepted items and predict their results.
  always @(posedge clk) begin
    taken_q <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_y.push_back(predict_y(in_sample_x));
      n_taken++;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken_q)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_x.size() > 0) begin
        in_valid <= 1'b1;
        in_sample_x <= pending_x.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: changes its stall pattern now and then; once holds off long enough
  // that the pipeline fills and the input stalls.
  always @(negedge clk) begin
    if (!long_hold_done && n_taken >= 600) begin
      long_hold_done = 1;
      hold_left = 300;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(16, 128);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_y.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 out_prediction);
        errors++;
      end else begin
        if (out_prediction !== expected_y[0]) begin
          $display("%0t: prediction mismatch, expected %0d, actual %0d", $time,
                   $signed(expected_y[0]), out_prediction);
          errors++;
        end
        void'(expected_y.pop_front());
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_y.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_x.size() > 0 || in_valid || expected_y.size() > 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  task automatic write_weights(logic [W_W-1:0] w0, logic [W_W-1:0] w1,
                               logic [W_W-1:0] w2, logic [W_W-1:0] w3);
    logic [W_W-1:0] w [4];
    w = '{w0, w1, w2, w3};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= w[i];
      weight[i] = longint'($signed(w[i]));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [W_W-1:0] wmax, wmin;
    wmax = {1'b0, {(W_W-1){1'b1}}};
    wmin = {1'b1, {(W_W-1){1'b0}}};
    weight[REG_BIAS]   = longint'(BIAS_RST);
    weight[REG_LINEAR] = longint'(LINEAR_RST);
    weight[REG_SINE]   = longint'(SINE_RST);
    weight[REG_GAUSS]  = longint'(GAUSS_RST);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    // Field extremes, quadrant edges of 3x and both sides of where x*x reaches 32.
    pending_x = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF,
                  24'd34315, 24'd68629, 24'd102944, 24'd137258, -24'sd68629,
                  24'd370727, 24'd370728, -24'sd370727, -24'sd370728, 24'd65536,
                  -24'sd65536, 24'd5, 24'h555555, 24'hAAAAAA, 24'd2097152};
    wait_drained();
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       write_weights(wmax, wmax, wmax, wmax);
        1:       write_weights(wmin, wmin, wmin, wmin);
        2:       write_weights('0, '0, '0, '0);
        3:       write_weights(wmin, wmax, wmin, wmax);
        default: write_weights(W_W'($urandom), W_W'($urandom), W_W'($urandom),
                               W_W'($urandom));
      endcase
      for (int i = 0; i < PER_PHASE; i++) pending_x.push_back(random_x());
      wait_drained();
    end
    write_weights(BIAS_RST, LINEAR_RST, SINE_RST, GAUSS_RST);
    for (int i = 0; i < 40; i++) pending_x.push_back(random_x());
    wait_drained();
    $display("Covered %0d samples and %0d checked predictions over %0d weight settings,",
             n_taken, n_checked, N_PHASES + 2);
    $display("including extreme weights and a long output stall that blocked the input.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
